>>> src/dgaf_pkg.sv
// Shared constants, types and helper functions of the diagonal ghost average filter.
// No dependencies; used by the filter top level and its checker.
package dgaf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int DIAG_OFFSET = 4;

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int DIM_W = 11;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LAG_W = $clog2(DIAG_OFFSET * MAX_WIDTH + DIAG_OFFSET + 1);
  localparam int SUM_W = CH_W + 2;

  // A row bank is reused only after the reads of its older row are done.
  // That needs more than three offsets' worth of rows, even at width one.
  localparam int BANK_W    = $clog2(3 * DIAG_OFFSET + 1);
  localparam int NUM_BANKS = 2 ** BANK_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] total_for(input logic [DIM_W-1:0] w,
                                                 input logic [DIM_W-1:0] h);
    logic [2*DIM_W-1:0] p;
    p = w * h;
    return p[CNT_W-1:0];
  endfunction

  function automatic logic [LAG_W-1:0] lag_for(input logic [DIM_W-1:0] w);
    logic [LAG_W+DIM_W-1:0] p;
    p = (LAG_W+DIM_W)'(DIAG_OFFSET) * (LAG_W+DIM_W)'(w) + (LAG_W+DIM_W)'(DIAG_OFFSET);
    return p[LAG_W-1:0];
  endfunction

endpackage

>>> src/dgaf_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
module dgaf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> src/diagonal_ghost_average_filter_unit.sv
// A result beat is registered in the read stage and then in the output register.
// Throughput: one beat per cycle when not stalled; the four diagonal reads come from
// row banks that each have two read ports, so no read port is shared between beats.
// Reset (synchronous) sets width 640 and height 480 and clears the frame counters
// and both pipeline valids; the line store is not cleared and is not read before
// it is written within a frame. Uses dgaf_pkg and dgaf_ram.
module diagonal_ghost_average_filter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dgaf_pkg::PIX_W-1:0]     s_tdata,   // blue_in, green_in, red_in
  input  logic                           s_tuser,   // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dgaf_pkg::PIX_W-1:0]     m_tdata,   // blue_out, green_out, red_out
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [dgaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dgaf_pkg::DIM_W-1:0]     cfg_data
);

  localparam logic [dgaf_pkg::DIM_W-1:0] MaxW = dgaf_pkg::DIM_W'(dgaf_pkg::MAX_WIDTH);
  localparam logic [dgaf_pkg::DIM_W-1:0] MaxH = dgaf_pkg::DIM_W'(dgaf_pkg::MAX_HEIGHT);
  localparam logic [dgaf_pkg::DIM_W-1:0] DimD = dgaf_pkg::DIM_W'(dgaf_pkg::DIAG_OFFSET);

  // Frame geometry, kept already clamped.
  logic [dgaf_pkg::DIM_W-1:0] eff_w;
  logic [dgaf_pkg::DIM_W-1:0] eff_h;
  logic [dgaf_pkg::CNT_W-1:0] total;
  logic [dgaf_pkg::LAG_W-1:0] lag;

  // Frame progress.
  logic [dgaf_pkg::CNT_W-1:0] received;
  logic [dgaf_pkg::CNT_W-1:0] gap;
  logic [dgaf_pkg::COL_W-1:0] wcol;
  logic [dgaf_pkg::ROW_W-1:0] wrow;
  logic [dgaf_pkg::COL_W-1:0] ecol;
  logic [dgaf_pkg::ROW_W-1:0] erow;

  logic accept, is_push, full, do_write, push_emit, drain_emit, emit, last;
  logic s1_advance;
  dgaf_pkg::pix_t in_pix;

  logic [dgaf_pkg::DIM_W-1:0]  new_dim;
  logic [dgaf_pkg::DIM_W-1:0]  row_hi_ext, col_hi_ext;
  logic [dgaf_pkg::ROW_W-1:0]  row_lo, row_hi;
  logic [dgaf_pkg::COL_W-1:0]  col_lo, col_hi;
  logic [dgaf_pkg::BANK_W-1:0] wbank, bank_lo, bank_hi;
  logic [3:0]                  hit;

  logic [dgaf_pkg::PIX_W-1:0] rd_lo_col [dgaf_pkg::NUM_BANKS];
  logic [dgaf_pkg::PIX_W-1:0] rd_hi_col [dgaf_pkg::NUM_BANKS];

  // Read stage.
  logic                        s1_valid;
  logic                        s1_last;
  logic [dgaf_pkg::BANK_W-1:0] s1_bank_lo, s1_bank_hi;
  logic [3:0]                  s1_hit;
  dgaf_pkg::pix_t              s1_wpix;

  dgaf_pkg::pix_t             nb [4];
  logic [dgaf_pkg::SUM_W-1:0] sum_b, sum_g, sum_r;
  dgaf_pkg::pix_t             avg;

  assign in_pix   = dgaf_pkg::pix_t'(s_tdata);
  assign new_dim  = dgaf_pkg::clamp_dim(cfg_data, (cfg_index == dgaf_pkg::REG_FRAME_WIDTH)
                                                  ? MaxW : MaxH);

  assign s1_advance = !m_tvalid || m_tready;
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;
  assign is_push    = (s_tuser == dgaf_pkg::OP_PUSH);
  assign full       = (received == total);
  assign do_write   = accept && is_push && !full;
  // gap counts pixels received but not yet emitted.
  assign push_emit  = do_write && (gap >= dgaf_pkg::CNT_W'(lag));
  assign drain_emit = accept && !is_push && full && (gap != '0);
  assign emit       = push_emit || drain_emit;
  // A push can never produce the final output, so only a drain closes a frame.
  assign last       = drain_emit && (gap == dgaf_pkg::CNT_W'(1));

  // Clamped neighbor coordinates of the pixel being emitted.
  always_comb begin
    row_lo     = (erow >= dgaf_pkg::ROW_W'(dgaf_pkg::DIAG_OFFSET))
                 ? erow - dgaf_pkg::ROW_W'(dgaf_pkg::DIAG_OFFSET) : '0;
    col_lo     = (ecol >= dgaf_pkg::COL_W'(dgaf_pkg::DIAG_OFFSET))
                 ? ecol - dgaf_pkg::COL_W'(dgaf_pkg::DIAG_OFFSET) : '0;
    row_hi_ext = dgaf_pkg::DIM_W'(erow) + DimD;
    col_hi_ext = dgaf_pkg::DIM_W'(ecol) + DimD;
    row_hi     = (row_hi_ext >= eff_h) ? dgaf_pkg::ROW_W'(eff_h - 1'b1)
                                       : row_hi_ext[dgaf_pkg::ROW_W-1:0];
    col_hi     = (col_hi_ext >= eff_w) ? dgaf_pkg::COL_W'(eff_w - 1'b1)
                                       : col_hi_ext[dgaf_pkg::COL_W-1:0];
    wbank      = wrow[dgaf_pkg::BANK_W-1:0];
    bank_lo    = row_lo[dgaf_pkg::BANK_W-1:0];
    bank_hi    = row_hi[dgaf_pkg::BANK_W-1:0];
    // The newest neighbor may be the pixel written in this same cycle.
    hit[0]     = do_write && (bank_hi == wbank) && (col_lo == wcol);
    hit[1]     = do_write && (bank_lo == wbank) && (col_lo == wcol);
    hit[2]     = do_write && (bank_lo == wbank) && (col_hi == wcol);
    hit[3]     = do_write && (bank_hi == wbank) && (col_hi == wcol);
  end

  for (genvar b = 0; b < dgaf_pkg::NUM_BANKS; b++) begin : g_bank
    dgaf_ram #(
      .WIDTH(dgaf_pkg::PIX_W),
      .DEPTH(dgaf_pkg::MAX_WIDTH)
    ) u_ram (
      .clk    (clk),
      .we     (do_write && (wbank == dgaf_pkg::BANK_W'(b))),
      .waddr  (wcol),
      .wdata  (s_tdata),
      .re     (accept),
      .raddr_a(col_lo),
      .raddr_b(col_hi),
      .rdata_a(rd_lo_col[b]),
      .rdata_b(rd_hi_col[b])
    );
  end

  // Configuration and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w    <= dgaf_pkg::DIM_W'(dgaf_pkg::RESET_WIDTH);
      eff_h    <= dgaf_pkg::DIM_W'(dgaf_pkg::RESET_HEIGHT);
      total    <= dgaf_pkg::CNT_W'(dgaf_pkg::RESET_WIDTH * dgaf_pkg::RESET_HEIGHT);
      lag      <= dgaf_pkg::LAG_W'(dgaf_pkg::DIAG_OFFSET * dgaf_pkg::RESET_WIDTH
                                   + dgaf_pkg::DIAG_OFFSET);
      received <= '0;
      gap      <= '0;
      wcol     <= '0;
      wrow     <= '0;
      ecol     <= '0;
      erow     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dgaf_pkg::REG_FRAME_WIDTH: begin
          eff_w <= new_dim;
          total <= dgaf_pkg::total_for(new_dim, eff_h);
          lag   <= dgaf_pkg::lag_for(new_dim);
        end
        dgaf_pkg::REG_FRAME_HEIGHT: begin
          eff_h <= new_dim;
          total <= dgaf_pkg::total_for(eff_w, new_dim);
        end
        default: begin
        end
      endcase
      received <= '0;
      gap      <= '0;
      wcol     <= '0;
      wrow     <= '0;
      ecol     <= '0;
      erow     <= '0;
    end else if (last) begin
      received <= '0;
      gap      <= '0;
      wcol     <= '0;
      wrow     <= '0;
      ecol     <= '0;
      erow     <= '0;
    end else begin
      if (do_write) begin
        received <= received + 1'b1;
        if (dgaf_pkg::DIM_W'(wcol) + 1'b1 == eff_w) begin
          wcol <= '0;
          wrow <= wrow + 1'b1;
        end else begin
          wcol <= wcol + 1'b1;
        end
        if (!push_emit) begin
          gap <= gap + 1'b1;
        end
      end
      if (drain_emit) begin
        gap <= gap - 1'b1;
      end
      if (emit) begin
        if (dgaf_pkg::DIM_W'(ecol) + 1'b1 == eff_w) begin
          ecol <= '0;
          erow <= erow + 1'b1;
        end else begin
          ecol <= ecol + 1'b1;
        end
      end
    end
  end

  // Read stage registers; the RAM read data is held with them while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last    <= last;
      s1_bank_lo <= bank_lo;
      s1_bank_hi <= bank_hi;
      s1_hit     <= hit;
      s1_wpix    <= in_pix;
    end
  end

  always_comb begin
    nb[0] = s1_hit[0] ? s1_wpix : dgaf_pkg::pix_t'(rd_lo_col[s1_bank_hi]);
    nb[1] = s1_hit[1] ? s1_wpix : dgaf_pkg::pix_t'(rd_lo_col[s1_bank_lo]);
    nb[2] = s1_hit[2] ? s1_wpix : dgaf_pkg::pix_t'(rd_hi_col[s1_bank_lo]);
    nb[3] = s1_hit[3] ? s1_wpix : dgaf_pkg::pix_t'(rd_hi_col[s1_bank_hi]);
    sum_b = dgaf_pkg::SUM_W'(nb[0].blue) + dgaf_pkg::SUM_W'(nb[1].blue)
          + dgaf_pkg::SUM_W'(nb[2].blue) + dgaf_pkg::SUM_W'(nb[3].blue)
          + dgaf_pkg::SUM_W'(2);
    sum_g = dgaf_pkg::SUM_W'(nb[0].green) + dgaf_pkg::SUM_W'(nb[1].green)
          + dgaf_pkg::SUM_W'(nb[2].green) + dgaf_pkg::SUM_W'(nb[3].green)
          + dgaf_pkg::SUM_W'(2);
    sum_r = dgaf_pkg::SUM_W'(nb[0].red) + dgaf_pkg::SUM_W'(nb[1].red)
          + dgaf_pkg::SUM_W'(nb[2].red) + dgaf_pkg::SUM_W'(nb[3].red)
          + dgaf_pkg::SUM_W'(2);
    avg.blue  = sum_b[dgaf_pkg::SUM_W-1:2];
    avg.green = sum_g[dgaf_pkg::SUM_W-1:2];
    avg.red   = sum_r[dgaf_pkg::SUM_W-1:2];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      m_tdata <= avg;
      m_tlast <= s1_last;
    end
  end

endmodule

>>> src/dgaf_checker.sv
// Port-level checker for the diagonal ghost average filter, bound to its top level.
// Depends only on the top level's ports.
module dgaf_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A consumer that takes results never holds back the input side.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is taken");

  // Every new result comes from an earlier accepted beat.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without an accepted beat");

  // Only a drain beat can close the frame.
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && m_tlast |-> $past(s_tuser, 2))
    else $error("frame end flagged on a push");

endmodule

bind diagonal_ghost_average_filter_unit dgaf_assertions u_dgaf_assertions (.*);

>>> verif/dgaf_checker.sv
`timescale 1ns / 1ps
// Checker for the diagonal ghost average filter: watches the input, output and register
// channels, predicts every output beat and compares it. Depends on dgaf_pkg only.
module dgaf_checker
  import dgaf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [PIX_W-1:0]     s_tdata,   // blue_in, green_in, red_in
  input  logic                 s_tuser,   // op
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [PIX_W-1:0]     m_tdata,   // blue_out, green_out, red_out
  input  logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int STORE_DEPTH = (2 * DIAG_OFFSET + 1) * MAX_WIDTH;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    pix_t px;
    logic last;
  } filt_beat_t;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  pix_t             pixel_mem [STORE_DEPTH];
  int unsigned      rx_count;
  int unsigned      tx_count;
  filt_beat_t       filtered_q [$];
  int               mismatches;
  pix_t             got_px;
  filt_beat_t       want;

  // Zero counts as one and anything past the cap counts as the cap.
  function automatic int active_dim(logic [DIM_W-1:0] v, int cap);
    if (v == '0) begin
      return 1;
    end else if (int'(v) > cap) begin
      return cap;
    end
    return int'(v);
  endfunction

  function automatic filt_beat_t diag_average(int unsigned k, logic last);
    int          w, h, row, col, rr, cc, n;
    int unsigned sum_b, sum_g, sum_r;
    pix_t        px;
    filt_beat_t  b;
    w = active_dim(width_reg, MAX_WIDTH);
    h = active_dim(height_reg, MAX_HEIGHT);
    row = int'(k / w);
    col = int'(k % w);
    sum_b = 0;
    sum_g = 0;
    sum_r = 0;
    for (n = 0; n < 4; n++) begin
      rr = row + ((n == 0 || n == 3) ? DIAG_OFFSET : -DIAG_OFFSET);
      cc = col + ((n < 2) ? -DIAG_OFFSET : DIAG_OFFSET);
      if (rr < 0) rr = 0;
      else if (rr >= h) rr = h - 1;
      if (cc < 0) cc = 0;
      else if (cc >= w) cc = w - 1;
      px = pixel_mem[(rr * w + cc) % STORE_DEPTH];
      sum_b += px.blue;
      sum_g += px.green;
      sum_r += px.red;
    end
    b.px.blue  = CH_W'((sum_b + 2) >> 2);
    b.px.green = CH_W'((sum_g + 2) >> 2);
    b.px.red   = CH_W'((sum_r + 2) >> 2);
    b.last     = last;
    return b;
  endfunction

  task automatic predict_beat(logic op, pix_t px);
    int unsigned w, total, lag;
    logic        last;
    w     = active_dim(width_reg, MAX_WIDTH);
    total = w * active_dim(height_reg, MAX_HEIGHT);
    lag   = DIAG_OFFSET * w + DIAG_OFFSET;
    if (op == OP_PUSH) begin
      // Pushes into a completed frame are dropped.
      if (rx_count < total) begin
        pixel_mem[rx_count % STORE_DEPTH] = px;
        rx_count++;
        if (tx_count + lag < rx_count && tx_count < total) begin
          filtered_q.push_back(diag_average(tx_count, tx_count + 1 == total));
          tx_count++;
        end
      end
    end else if (rx_count == total && tx_count < total) begin
      last = (tx_count + 1 == total);
      filtered_q.push_back(diag_average(tx_count, last));
      tx_count++;
      if (last) begin
        rx_count = 0;
        tx_count = 0;
      end
    end
  endtask

  task automatic report(string what, int got, int exp_val);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t: %s: got %0h, wanted %0h", $time, what, got, exp_val);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = DIM_W'(RESET_WIDTH);
      height_reg = DIM_W'(RESET_HEIGHT);
      rx_count   = 0;
      tx_count   = 0;
      filtered_q.delete();
    end else begin
      // Any register write restarts the frame.
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        rx_count = 0;
        tx_count = 0;
      end
      if (s_tvalid && s_tready) predict_beat(s_tuser, pix_t'(s_tdata));
      if (m_tvalid && m_tready) begin
        got_px = m_tdata;
        if (filtered_q.size() == 0) begin
          report("result beat with nothing expected", int'(m_tdata), 0);
        end else begin
          want = filtered_q.pop_front();
          if (got_px.blue !== want.px.blue) report("blue", got_px.blue, want.px.blue);
          if (got_px.green !== want.px.green) report("green", got_px.green, want.px.green);
          if (got_px.red !== want.px.red) report("red", got_px.red, want.px.red);
          if (m_tlast !== want.last) report("frame last", m_tlast, want.last);
        end
      end
    end
    pending    <= filtered_q.size();
    fail_count <= mismatches;
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top of the diagonal ghost average filter testbench: clock, reset, register writes and
// pixel/drain stimulus under several idle patterns. Depends on dgaf_pkg and dgaf_checker.
module tb;
  import dgaf_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 200;
  localparam int END_WAIT     = 20;
  localparam int END_GUARD    = 100000;
  localparam int LIMIT        = 1000000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [PIX_W-1:0]     s_tdata   = '0;
  logic                 s_tuser   = OP_PUSH;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [PIX_W-1:0]     m_tdata;
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;

  logic m_hold   = 1'b0;
  logic hold_req = 1'b0;
  int   send_idle;
  int   recv_stall;
  int   items_sent;
  int   cur_w;
  int   cur_h;
  int   cycle_count;
  int   fail_count;
  int   pending;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  diagonal_ghost_average_filter_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  dgaf_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    m_tready <= !m_hold && ($urandom_range(99) >= recv_stall);
  end

  // One long output hold-off so the pipeline backs up into the input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    m_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    m_hold <= 1'b0;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL diagonal_ghost_average_filter_unit");
    $finish;
  end

  task automatic set_phase(int p);
    case (p)
      0: begin
        send_idle  = 0;
        recv_stall = 0;
      end
      1: begin
        send_idle  = 63;
        recv_stall = 0;
      end
      2: begin
        send_idle  = 0;
        recv_stall = 63;
      end
      default: begin
        send_idle  = 9;
        recv_stall = 9;
      end
    endcase
  endtask

  task automatic send_beat(logic op, logic [PIX_W-1:0] px);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Writes both registers once the filter has gone quiet.
  task automatic configure(int w, int h);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    cur_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
  endtask

  // A whole frame of random pixels, then the drain beats that flush it. Early drains
  // land before the frame is complete and must be ignored, as must the extra pushes.
  task automatic run_frame(int noise_pct, int extra_push, int extra_drain);
    int total, drains, k;
    total  = cur_w * cur_h;
    drains = DIAG_OFFSET * cur_w + DIAG_OFFSET;
    if (drains > total) drains = total;
    for (k = 0; k < total; k++) begin
      if ($urandom_range(99) < noise_pct) send_beat(OP_DRAIN, PIX_W'($urandom));
      send_beat(OP_PUSH, PIX_W'($urandom));
    end
    repeat (extra_push) send_beat(OP_PUSH, PIX_W'($urandom));
    repeat (drains + extra_drain) send_beat(OP_DRAIN, PIX_W'($urandom));
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] dir_px [6];
    int               rand_start, pick, guard;
    bit               need_cfg;
    dir_px[0] = 24'h000000;
    dir_px[1] = 24'hFFFFFF;
    dir_px[2] = 24'hFF0000;
    dir_px[3] = 24'h00FF00;
    dir_px[4] = 24'h0000FF;
    dir_px[5] = 24'hFFFFFF;
    items_sent = 0;
    need_cfg   = 0;
    set_phase(0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Tiny 3x2 frame: early drain, channel extremes, push into a full frame,
    // the flush, then a drain with nothing pending.
    configure(3, 2);
    send_beat(OP_DRAIN, '0);
    foreach (dir_px[i]) send_beat(OP_PUSH, dir_px[i]);
    send_beat(OP_PUSH, 24'h5A5AA5);
    repeat (6) send_beat(OP_DRAIN, '1);
    send_beat(OP_DRAIN, '0);

    // Register extremes, out-of-range values among them.
    set_phase(1);
    configure(0, 0);
    run_frame(0, 1, 1);
    // Oversized registers act as the maximum; part of a frame is pushed and the
    // next register write restarts it.
    set_phase(2);
    configure(1, 2047);
    repeat (24) send_beat(OP_PUSH, PIX_W'($urandom));
    set_phase(3);
    configure(2047, 1);
    repeat (16) send_beat(OP_PUSH, PIX_W'($urandom));

    // Pushes keep coming while the output is held off; the row banks wrap.
    set_phase(0);
    configure(4, 24);
    hold_req <= 1'b1;
    run_frame(0, 0, 0);

    rand_start = items_sent;
    while (items_sent < rand_start + RANDOM_ITEMS) begin
      set_phase($urandom_range(3));
      if (need_cfg || $urandom_range(99) < 40) begin
        configure($urandom_range(10), $urandom_range(10));
        need_cfg = 0;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_frame(5, 0, 0);
      end else if (pick < 85) begin
        run_frame(15, $urandom_range(1, 3), $urandom_range(1, 3));
      end else begin
        // Abandoned frame: part of it is pushed and a register write restarts it.
        repeat ($urandom_range(cur_w * cur_h - 1)) begin
          if ($urandom_range(99) < 15) send_beat(OP_DRAIN, PIX_W'($urandom));
          send_beat(OP_PUSH, PIX_W'($urandom));
        end
        need_cfg = 1;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < END_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS diagonal_ghost_average_filter_unit");
    end else begin
      $display("FAIL diagonal_ghost_average_filter_unit");
    end
    $finish;
  end

endmodule
